FILE: rtl/rbmb_pkg.sv
// Shared types and constants of the rotated box mask blend block.
package rbmb_pkg;

	// Q1.15 level that stands for 1.0.
	localparam logic [15:0] LEVEL_ONE = 16'd32768;

	// Widths of the configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// Register indexes on the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X  = 3'd0,
		REG_CENTER_Y  = 3'd1,
		REG_HALF_W    = 3'd2,
		REG_HALF_H    = 3'd3,
		REG_COS_ROT   = 3'd4,
		REG_SIN_ROT   = 3'd5,
		REG_BLEND     = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BLEND_ADD = 2'd0,
		BLEND_SUB = 2'd1,
		BLEND_MUL = 2'd2,
		BLEND_INV = 2'd3
	} blend_mode_t;

	// Register file contents as seen by the datapath.
	typedef struct packed {
		logic signed [17:0] center_x;
		logic signed [17:0] center_y;
		logic        [16:0] half_width;
		logic        [16:0] half_height;
		logic signed [15:0] cos_rot;
		logic signed [15:0] sin_rot;
		blend_mode_t        mode;
	} cfg_t;

	// Load enables of the four pipeline stages.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctl_t;

endpackage

FILE: rtl/rbmb_cfg_regs.sv
// Configuration register file of the rotated box mask blend block.
module rbmb_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [rbmb_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [rbmb_pkg::CFG_DATA_W-1:0]     wr_data,
	output rbmb_pkg::cfg_t                      cfg
);

	rbmb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x    <= '0;
			cfg_q.center_y    <= '0;
			cfg_q.half_width  <= '0;
			cfg_q.half_height <= '0;
			cfg_q.cos_rot     <= 16'sd16384;
			cfg_q.sin_rot     <= '0;
			cfg_q.mode        <= rbmb_pkg::BLEND_ADD;
		end else if (wr_en) begin
			unique case (wr_index)
				rbmb_pkg::REG_CENTER_X: cfg_q.center_x    <= wr_data;
				rbmb_pkg::REG_CENTER_Y: cfg_q.center_y    <= wr_data;
				rbmb_pkg::REG_HALF_W:   cfg_q.half_width  <= wr_data[16:0];
				rbmb_pkg::REG_HALF_H:   cfg_q.half_height <= wr_data[16:0];
				rbmb_pkg::REG_COS_ROT:  cfg_q.cos_rot     <= wr_data[15:0];
				rbmb_pkg::REG_SIN_ROT:  cfg_q.sin_rot     <= wr_data[15:0];
				rbmb_pkg::REG_BLEND:    cfg_q.mode <= rbmb_pkg::blend_mode_t'(wr_data[1:0]);
				default: begin
					// Writes beyond the register list are dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/rbmb_box_test.sv
// Rotation and strict box test: offsets, products, sums, then the bound compare.
module rbmb_box_test #(
	parameter int COORD_BITS = 12
) (
	input  logic                   clk,
	input  rbmb_pkg::pipe_ctl_t    ctl,
	input  rbmb_pkg::cfg_t         cfg,
	input  logic [COORD_BITS-1:0]  pixel_x,
	input  logic [COORD_BITS-1:0]  pixel_y,
	output logic                   box_hit
);

	localparam int PW   = COORD_BITS + 5;
	localparam int DW   = ((PW > 18) ? PW : 18) + 1;
	localparam int PRW  = DW + 16;
	localparam int SW   = PRW + 1;
	localparam int CW   = ((SW > 33) ? SW : 33) + 1;

	logic signed [DW-1:0]  px_ext, py_ext;
	logic signed [DW-1:0]  dx_s1, dy_s1;
	logic signed [PRW-1:0] ux_s2, uy_s2, vx_s2, vy_s2;
	logic signed [SW-1:0]  u_s3, v_s3;
	logic signed [CW-1:0]  u_ext, v_ext, hw_ext, hh_ext;

	assign px_ext = signed'({{(DW-COORD_BITS-4){1'b0}}, pixel_x, 4'b0000});
	assign py_ext = signed'({{(DW-COORD_BITS-4){1'b0}}, pixel_y, 4'b0000});

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			dx_s1 <= px_ext - DW'(cfg.center_x);
			dy_s1 <= py_ext - DW'(cfg.center_y);
		end
		if (ctl.en_s2) begin
			ux_s2 <= PRW'(cfg.cos_rot) * PRW'(dx_s1);
			uy_s2 <= PRW'(cfg.sin_rot) * PRW'(dy_s1);
			vx_s2 <= PRW'(cfg.sin_rot) * PRW'(dx_s1);
			vy_s2 <= PRW'(cfg.cos_rot) * PRW'(dy_s1);
		end
		if (ctl.en_s3) begin
			u_s3 <= SW'(ux_s2) + SW'(uy_s2);
			v_s3 <= SW'(vy_s2) - SW'(vx_s2);
		end
	end

	// Bounds are the half sizes moved up by 14 bits to the Q18 scale of u and v.
	assign u_ext  = CW'(u_s3);
	assign v_ext  = CW'(v_s3);
	assign hw_ext = CW'(signed'({1'b0, cfg.half_width, 14'b0}));
	assign hh_ext = CW'(signed'({1'b0, cfg.half_height, 14'b0}));

	assign box_hit = (u_ext < hw_ext) && (u_ext > -hw_ext)
		&& (v_ext < hh_ext) && (v_ext > -hh_ext);

endmodule

FILE: rtl/rbmb_blend.sv
// Level path: saturation, rounded product and the final blend register.
module rbmb_blend (
	input  logic                   clk,
	input  rbmb_pkg::pipe_ctl_t    ctl,
	input  rbmb_pkg::cfg_t         cfg,
	input  logic [15:0]            mask_level,
	input  logic [15:0]            value_level,
	input  logic                   box_hit,
	output logic [15:0]            masked_value,
	output logic                   inside_box
);

	logic [15:0] m_sat, v_sat;
	logic [15:0] m_s1, v_s1, m_s2, v_s2, m_s3, v_s3;
	logic [31:0] prod_s2;
	logic [31:0] prod_rnd;
	logic [15:0] mul_s3;
	logic [15:0] blend_in, blend_out;
	logic [15:0] masked_value_s4;
	logic        inside_s4;

	assign m_sat = (mask_level  > rbmb_pkg::LEVEL_ONE) ? rbmb_pkg::LEVEL_ONE : mask_level;
	assign v_sat = (value_level > rbmb_pkg::LEVEL_ONE) ? rbmb_pkg::LEVEL_ONE : value_level;

	// Round half up to Q1.15; the result never exceeds 1.0.
	assign prod_rnd = prod_s2 + 32'd16384;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			m_s1 <= m_sat;
			v_s1 <= v_sat;
		end
		if (ctl.en_s2) begin
			m_s2    <= m_s1;
			v_s2    <= v_s1;
			prod_s2 <= m_s1 * v_s1;
		end
		if (ctl.en_s3) begin
			m_s3   <= m_s2;
			v_s3   <= v_s2;
			mul_s3 <= prod_rnd[30:15];
		end
		if (ctl.en_s4) begin
			masked_value_s4 <= blend_out;
			inside_s4       <= box_hit;
		end
	end

	always_comb begin
		unique case (cfg.mode)
			rbmb_pkg::BLEND_ADD: blend_in = (m_s3 > v_s3) ? m_s3 : v_s3;
			rbmb_pkg::BLEND_SUB: blend_in = (m_s3 > v_s3) ? (m_s3 - v_s3) : 16'd0;
			rbmb_pkg::BLEND_MUL: blend_in = mul_s3;
			rbmb_pkg::BLEND_INV: blend_in = (m_s3 != 16'd0) ? 16'd0 : v_s3;
			default:             blend_in = m_s3;
		endcase
		if (box_hit) begin
			blend_out = blend_in;
		end else if (cfg.mode == rbmb_pkg::BLEND_MUL) begin
			blend_out = 16'd0;
		end else begin
			blend_out = m_s3;
		end
	end

	assign masked_value = masked_value_s4;
	assign inside_box   = inside_s4;

endmodule

FILE: rtl/rotated_box_mask_blend.sv
// Top level of the rotated box mask blend block: handshakes and pipeline control.
//
//  Channel   Direction  Signals                          Carries
//  s_*       in         s_tvalid s_tready s_tdata        one pixel item
//  m_*       out        m_tvalid m_tready m_tdata m_tuser one blended level item
//  cfg_*     in         cfg_valid cfg_ready cfg_index    one register write
//                       cfg_data
//
// Every item passes four register stages: offsets from the box centre, the four
// rotation products, the rotated sums, and finally the bound compare with the
// blend, which lands in the output register. An item passes the stages in that
// order; one item is taken in every cycle unless a stall has filled every stage.
// Each stage holds its item while the stage after it is full and stalled, so a
// stall on the output side fills the bubbles first and only then drops s_tready;
// nothing is lost or repeated. Reset clears the valid bits and loads the
// register reset values; cfg_ready is always high.
module rotated_box_mask_blend #(
	parameter int COORD_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata, lowest bit up: pixel_x, pixel_y, mask_level, value_level, zero pad.
	input  logic [((2*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata: masked_value.
	output logic [15:0]                          m_tdata,
	// m_tuser: inside_box.
	output logic                                 m_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rbmb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rbmb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Field positions inside s_tdata.
	localparam int PY_LO = COORD_BITS;
	localparam int ML_LO = 2 * COORD_BITS;
	localparam int VL_LO = 2 * COORD_BITS + 16;

	rbmb_pkg::cfg_t      cfg;
	rbmb_pkg::pipe_ctl_t ctl;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic box_hit;

	// A stage can load when it is empty or its item moves on in this cycle.
	assign rdy4 = !vld_s4 || m_tready;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign ctl.en_s1 = s_tvalid && rdy1;
	assign ctl.en_s2 = vld_s1 && rdy2;
	assign ctl.en_s3 = vld_s2 && rdy3;
	assign ctl.en_s4 = vld_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= s_tvalid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	assign s_tready  = rdy1;
	assign m_tvalid  = vld_s4;
	assign cfg_ready = 1'b1;

	rbmb_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rbmb_box_test #(
		.COORD_BITS (COORD_BITS)
	) u_box (
		.clk     (clk),
		.ctl     (ctl),
		.cfg     (cfg),
		.pixel_x (s_tdata[COORD_BITS-1:0]),
		.pixel_y (s_tdata[PY_LO +: COORD_BITS]),
		.box_hit (box_hit)
	);

	rbmb_blend u_blend (
		.clk          (clk),
		.ctl          (ctl),
		.cfg          (cfg),
		.mask_level   (s_tdata[ML_LO +: 16]),
		.value_level  (s_tdata[VL_LO +: 16]),
		.box_hit      (box_hit),
		.masked_value (m_tdata),
		.inside_box   (m_tuser)
	);

	// The input side only waits when every stage holds an item.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4))
		else $error("input stalled while the pipeline had a free stage");

	// An accepted item occupies the first stage on the next edge.
	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted item did not enter the first stage");

	// A blocked third stage keeps its item and the output stage stays full.
	a_s3_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !rdy3) |=> (vld_s3 && vld_s4))
		else $error("stalled item left the third stage");

endmodule
